### hdl/cart_bank_and_serial_card_port_macros.svh
// assertion helpers, sampled on the block clock and quiet during reset
`ifndef CART_BANK_AND_SERIAL_CARD_PORT_MACROS_SVH
`define CART_BANK_AND_SERIAL_CARD_PORT_MACROS_SVH

// consequent checked in the same cycle
`define CBSCP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cbscp same-cycle check failed");

// consequent checked in the next cycle
`define CBSCP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cbscp next-cycle check failed");

`endif

### hdl/cbscp_pkg.sv
`default_nettype none
package cbscp_pkg;

	// reply table depth, 32 to 256
	localparam int ROM_DEPTH = 128;
	localparam logic [8:0] ROM_DEPTH_W = 9'(ROM_DEPTH);
	localparam logic [8:0] ROM_LAST_W = 9'(ROM_DEPTH - 1);

	// bus decode
	localparam logic [15:0] PORT_ADDR = 16'h5000;

	// mode and reply codes
	localparam logic [7:0] MODE_DONE    = 8'h60;
	localparam logic [7:0] MODE_TX_END  = 8'h40;
	localparam logic [7:0] REPLY_DONE   = 8'h60;
	localparam logic [5:0] BUSY_INIT    = 6'h2C;
	localparam logic [6:0] OUT_LIM_FULL = 7'h7F;
	localparam logic [6:0] OUT_LIM_SHRT = 7'h1E;
	localparam logic [2:0] IN_LIM_SHRT  = 3'd4;

	// serial slot numbers
	localparam logic [3:0] SLOT_PARITY = 4'd8;
	localparam logic [3:0] SLOT_GAP    = 4'd9;

	// reply table contents
	localparam logic [7:0] ROM_B0   = 8'h14;
	localparam logic [7:0] ROM_B1   = 8'h55;
	localparam logic [7:0] ROM_B2   = 8'h45;
	localparam logic [7:0] ROM_B3   = 8'hD3;
	localparam logic [7:0] ROM_B4   = 8'h18;
	localparam logic [7:0] ROM_FILL = 8'h10;
	localparam logic [7:0] ROM_TAIL = 8'hAA;

	// request from the bus stage to the card port
	typedef struct packed {
		logic       wr;
		logic       rd;
		logic [7:0] wdata;
	} port_req_t;

	// reply table lookup, index wraps at the table depth
	function automatic logic [7:0] rom_byte(input logic [7:0] idx);
		logic [8:0] r;
		logic [7:0] b;
		r = {1'b0, idx};
		for (int k = 0; k < 8; k++) begin
			if (r >= ROM_DEPTH_W) begin
				r = r - ROM_DEPTH_W;
			end
		end
		case (r)
			9'd0: b = ROM_B0;
			9'd1: b = ROM_B1;
			9'd2: b = ROM_B2;
			9'd3: b = ROM_B3;
			9'd4: b = ROM_B4;
			default: begin
				if (r == ROM_LAST_W) begin
					b = ROM_TAIL;
				end else begin
					b = ROM_FILL;
				end
			end
		endcase
		return b;
	endfunction

endpackage
`default_nettype wire

### hdl/cart_bank_and_serial_card_port.sv
// cartridge bank latch with a bit-serial card port
//
// input channel s_*: one bus access per transaction, s_tuser is the access
// kind (0 read, 1 write), s_tdata carries address and write data.
// output channel m_*: one result per access, in order: read data of the card
// port, the answered flag on m_tuser, and the program and character banks
// as they stand after the access.
// the access is held in the input register, then its result in the result
// register, which drives m_tvalid.
// throughput: one access per cycle while m_tready holds high; the decode and
// the port update are a single level of small logic between the input and
// result registers. the input register still takes an access while a
// finished result waits if it is empty. a stall on m_tready holds the result
// and then the input register; s_tready drops once both are full.
// reset (arst_n low) clears both banks, the whole port state and both valid
// flags; the reply table is constant logic and needs no load.
`default_nettype none
`include "cart_bank_and_serial_card_port_macros.svh"
module cart_bank_and_serial_card_port
	import cbscp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // [15:0] addr, [23:16] wdata
	input  wire logic        s_tuser,   // [0] cmd
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [7:0] rdata, [8] prg_bank, [11:9] chr_bank
	output logic             m_tuser    // [0] rvalid
);

	logic        valid_s1;
	logic        cmd_s1;
	logic [15:0] addr_s1;
	logic [7:0]  wdata_s1;
	logic        m_valid_q;
	logic [7:0]  rdata_q;
	logic        rvalid_q;
	logic        prg_q;
	logic [2:0]  chr_q;
	logic        adv;
	logic        is_port;
	logic        is_hi;
	port_req_t   req;
	logic [7:0]  port_rdata;

	// stage advance when the result register is free or being drained
	assign adv = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1 <= s_tuser;
			addr_s1 <= s_tdata[15:0];
			wdata_s1 <= s_tdata[23:16];
		end
	end

	// address decode
	assign is_port = (addr_s1 == PORT_ADDR);
	assign is_hi = addr_s1[15];

	always_comb begin
		req.wr = adv && cmd_s1 && is_port;
		req.rd = adv && !cmd_s1 && is_port;
		req.wdata = wdata_s1;
	end

	cbscp_port u_port (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rdata  (port_rdata)
	);

	// bank latch, changes only when a result is loaded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_q <= 1'b0;
			chr_q <= 3'd0;
		end else if (adv && cmd_s1 && is_hi) begin
			prg_q <= addr_s1[0];
			chr_q <= addr_s1[3:1];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (!m_valid_q || m_tready) begin
			m_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rdata_q <= req.rd ? port_rdata : 8'h00;
			rvalid_q <= req.rd;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = {4'b0, chr_q, prg_q, rdata_q};
	assign m_tuser = rvalid_q;

	// checks
	`CBSCP_ASSERT_NEXT(a_bank_load, adv && cmd_s1 && is_hi, prg_q == $past(addr_s1[0]) && chr_q == $past(addr_s1[3:1]))
	`CBSCP_ASSERT_NEXT(a_quiet_rdata, adv && !req.rd, rdata_q == 8'h00 && !rvalid_q)
	`CBSCP_ASSERT_NEXT(a_s1_hold, valid_s1 && !adv, valid_s1 && m_valid_q)

endmodule
`default_nettype wire

### hdl/cbscp_port.sv
`default_nettype none
module cbscp_port
	import cbscp_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire port_req_t  req,
	output logic [7:0]      rdata
);

	logic [7:0] mode_q, oidx_q, oshift_q, icnt_q;
	logic [3:0] obit_q, ibit_q;
	logic       opar_q;
	logic [6:0] olim_q;
	logic [2:0] ilim_q;
	logic [5:0] busy_q;

	logic [7:0] mode_n, oidx_n, oshift_n, icnt_n;
	logic [3:0] obit_n, ibit_n;
	logic       opar_n;
	logic [6:0] olim_n;
	logic [2:0] ilim_n;
	logic [5:0] busy_n;
	logic [7:0] o;

	// next state of the card port for one transaction
	always_comb begin
		mode_n = mode_q;
		oidx_n = oidx_q;
		oshift_n = oshift_q;
		icnt_n = icnt_q;
		obit_n = obit_q;
		ibit_n = ibit_q;
		opar_n = opar_q;
		olim_n = olim_q;
		ilim_n = ilim_q;
		busy_n = busy_q;
		o = 8'h00;
		if (req.wr) begin
			// mode write
			mode_n = req.wdata;
			if (req.wdata == 8'h00) begin
				obit_n = 4'd0;
				oidx_n = 8'h00;
				opar_n = 1'b0;
				ibit_n = 4'd0;
				icnt_n = 8'h00;
				oshift_n = ROM_B0;
				olim_n = OUT_LIM_FULL;
			end
			if (req.wdata[5]) begin
				olim_n = OUT_LIM_SHRT;
				ilim_n = IN_LIM_SHRT;
			end
			// one input bit slot
			if (req.wdata[3]) begin
				busy_n = BUSY_INIT;
				if (ibit_q < SLOT_GAP) begin
					ibit_n = ibit_q + 4'd1;
				end else if (ibit_q == SLOT_GAP) begin
					ibit_n = 4'd0;
					if (icnt_q == {5'b0, ilim_n}) begin
						mode_n = MODE_DONE;
						busy_n = 6'd0;
					end else begin
						icnt_n = icnt_q + 8'd1;
					end
				end
			end
		end else if (req.rd) begin
			if (mode_q[6] | mode_q[5]) begin
				// handshake status
				if (busy_q != 6'd0) begin
					busy_n = busy_q - 6'd1;
				end else begin
					mode_n = {1'b0, mode_q[6] ^ mode_q[5], 6'b0};
				end
				o = mode_n;
			end else if (obit_q < SLOT_PARITY) begin
				// data bit, msb first
				opar_n = opar_q ^ oshift_q[7];
				o = {1'b0, oshift_q[7], 6'b0};
				oshift_n = {oshift_q[6:0], 1'b0};
				obit_n = obit_q + 4'd1;
			end else if (obit_q == SLOT_PARITY) begin
				obit_n = SLOT_GAP;
				o = {1'b0, opar_q, 6'b0};
			end else if (obit_q == SLOT_GAP) begin
				// gap slot: next byte or done
				opar_n = 1'b0;
				obit_n = 4'd0;
				if (oidx_q == {1'b0, olim_q}) begin
					mode_n = MODE_TX_END;
					o = REPLY_DONE;
				end else begin
					oshift_n = rom_byte(oidx_q);
					oidx_n = oidx_q + 8'd1;
				end
			end
		end
	end

	assign rdata = o;

	// port state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 8'h00;
			oidx_q <= 8'h00;
			oshift_q <= 8'h00;
			icnt_q <= 8'h00;
			obit_q <= 4'd0;
			ibit_q <= 4'd0;
			opar_q <= 1'b0;
			olim_q <= 7'd0;
			ilim_q <= 3'd0;
			busy_q <= 6'd0;
		end else begin
			mode_q <= mode_n;
			oidx_q <= oidx_n;
			oshift_q <= oshift_n;
			icnt_q <= icnt_n;
			obit_q <= obit_n;
			ibit_q <= ibit_n;
			opar_q <= opar_n;
			olim_q <= olim_n;
			ilim_q <= ilim_n;
			busy_q <= busy_n;
		end
	end

endmodule
`default_nettype wire

### tb/sv/tb_cart_bank_and_serial_card_port.sv
`default_nettype none
module tb_cart_bank_and_serial_card_port;
	import cbscp_pkg::*;

	// access kinds on s_tuser
	localparam logic CMD_READ  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	// mode byte fields
	localparam logic [7:0] STATUS_MASK    = 8'h60;
	localparam logic [7:0] STATUS_BIT     = 8'h40;
	localparam int         MODE_SHORT_BIT = 5;
	localparam int         MODE_SHIFT_BIT = 3;

	localparam int CYCLE_LIMIT = 200000;

	// one result transaction, split into its fields
	typedef struct packed {
		logic [7:0] rdata;
		logic       rvalid;
		logic       prg;
		logic [2:0] chr;
	} port_reply_t;

	// shadow of the bank latch and card port, plus the replies still owed
	class cart_port_shadow;
		logic       prg_q;
		logic [2:0] chr_q;
		logic [7:0] mode_q;
		logic [3:0] obit;
		logic [7:0] oidx;
		logic       opar;
		logic [7:0] oshift;
		logic [6:0] olim;
		logic [3:0] ibit;
		logic [7:0] icnt;
		logic [2:0] ilim;
		logic [5:0] busy;
		port_reply_t replies[$];
		int errors;

		function new();
			prg_q = 1'b0;
			chr_q = '0;
			mode_q = '0;
			obit = '0;
			oidx = '0;
			opar = 1'b0;
			oshift = '0;
			olim = '0;
			ibit = '0;
			icnt = '0;
			ilim = '0;
			busy = '0;
			errors = 0;
		endfunction

		// reply table entry, index wraps at the table depth
		function logic [7:0] reply_byte(logic [7:0] idx);
			int r;
			r = int'(idx) % ROM_DEPTH;
			case (r)
				0: return ROM_B0;
				1: return ROM_B1;
				2: return ROM_B2;
				3: return ROM_B3;
				4: return ROM_B4;
				default: return (r == ROM_DEPTH - 1) ? ROM_TAIL : ROM_FILL;
			endcase
		endfunction

		// write to the mode byte
		function void mode_write(logic [7:0] v);
			mode_q = v;
			if (v == 8'h00) begin
				obit = '0;
				oidx = '0;
				opar = 1'b0;
				ibit = '0;
				icnt = '0;
				oshift = reply_byte(8'h00);
				olim = OUT_LIM_FULL;
			end
			if (v[MODE_SHORT_BIT]) begin
				olim = OUT_LIM_SHRT;
				ilim = IN_LIM_SHRT;
			end
			if (v[MODE_SHIFT_BIT]) begin
				busy = BUSY_INIT;
				if (ibit < SLOT_GAP) begin
					ibit = ibit + 4'd1;
				end else if (ibit == SLOT_GAP) begin
					ibit = '0;
					if (icnt == {5'b0, ilim}) begin
						mode_q = MODE_DONE;
						busy = '0;
					end else begin
						icnt = icnt + 8'd1;
					end
				end
			end
		endfunction

		// read of the card port: status or one serial slot
		function logic [7:0] port_read();
			logic [7:0] o;
			logic b;
			o = 8'h00;
			if ((mode_q & STATUS_MASK) != 8'h00) begin
				if (busy != 6'd0) begin
					busy = busy - 6'd1;
				end else begin
					mode_q = (mode_q ^ (mode_q << 1)) & STATUS_BIT;
				end
				return mode_q;
			end
			if (obit < SLOT_PARITY) begin
				b = oshift[7];
				opar = opar ^ b;
				o[6] = b;
				oshift = oshift << 1;
				obit = obit + 4'd1;
			end else if (obit == SLOT_PARITY) begin
				obit = SLOT_GAP;
				o[6] = opar;
			end else if (obit == SLOT_GAP) begin
				opar = 1'b0;
				obit = '0;
				if (oidx == {1'b0, olim}) begin
					mode_q = MODE_TX_END;
					o = REPLY_DONE;
				end else begin
					oshift = reply_byte(oidx);
					oidx = oidx + 8'd1;
				end
			end
			return o;
		endfunction

		// accepted access: update the shadow and queue its reply
		function void note_access(logic cmd, logic [15:0] addr, logic [7:0] wdata);
			port_reply_t r;
			r = '0;
			if (cmd == CMD_WRITE) begin
				if (addr[15]) begin
					prg_q = addr[0];
					chr_q = addr[3:1];
				end else if (addr == PORT_ADDR) begin
					mode_write(wdata);
				end
			end else if (addr == PORT_ADDR) begin
				r.rdata = port_read();
				r.rvalid = 1'b1;
			end
			r.prg = prg_q;
			r.chr = chr_q;
			replies.push_back(r);
		endfunction

		function void compare_field(string what, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s expected %02h, got %02h", $time, what, want, got);
			end
		endfunction

		// result transaction against the oldest owed reply
		function void check_reply(logic [15:0] tdata, logic tuser);
			port_reply_t want;
			if (replies.size() == 0) begin
				errors++;
				$display("%0t: result with nothing owed, expected none, got %04h/%0b",
					$time, tdata, tuser);
				return;
			end
			want = replies.pop_front();
			compare_field("rdata", want.rdata, tdata[7:0]);
			compare_field("rvalid", {7'b0, want.rvalid}, {7'b0, tuser});
			compare_field("prg_bank", {7'b0, want.prg}, {7'b0, tdata[8]});
			compare_field("chr_bank", {5'b0, want.chr}, {5'b0, tdata[11:9]});
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // [15:0] addr, [23:16] wdata
	logic        s_tuser;   // [0] cmd
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // [7:0] rdata, [8] prg_bank, [11:9] chr_bank
	logic        m_tuser;   // [0] rvalid

	cart_port_shadow shadow;
	int  cycles = 0;
	int  port_items = 0;
	bit  calm = 1'b0;
	bit  src_idle_on = 1'b1;
	bit  sink_busy_on = 1'b1;

	cart_bank_and_serial_card_port dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	// clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// result side
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			shadow.check_reply(m_tdata, m_tuser);
		end
	end

	// receiver stalls in short bursts
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (!calm && sink_busy_on && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(negedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	// one bus access, held until the block takes it; starts and ends after a falling edge
	task automatic issue(input logic cmd, input logic [15:0] addr, input logic [7:0] wdata);
		if (!calm && src_idle_on && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {wdata, addr};
		s_tuser <= cmd;
		do @(posedge clk); while (!s_tready);
		shadow.note_access(cmd, addr, wdata);
		if ((cmd == CMD_WRITE && addr[15]) || addr == PORT_ADDR) begin
			port_items++;
		end
		@(negedge clk);
	endtask

	initial begin
		int kind;
		int n;
		int k;
		int tail;
		bit drained;
		logic [7:0] v;

		shadow = new();
		drained = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = CMD_READ;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: address extremes, port mode writes and reads
		issue(CMD_WRITE, 16'hFFFF, 8'h00);
		issue(CMD_WRITE, 16'h8000, 8'hFF);
		issue(CMD_WRITE, 16'h7FFF, 8'hFF);
		issue(CMD_READ, 16'h0000, 8'hFF);
		issue(CMD_READ, 16'hFFFF, 8'h00);
		issue(CMD_READ, 16'h5001, 8'h00);
		issue(CMD_WRITE, 16'h4FFF, 8'h00);
		issue(CMD_READ, PORT_ADDR, 8'h00);
		issue(CMD_WRITE, PORT_ADDR, 8'h00);
		issue(CMD_READ, PORT_ADDR, 8'h00);
		issue(CMD_READ, PORT_ADDR, 8'h00);
		issue(CMD_WRITE, PORT_ADDR, 8'h20);
		issue(CMD_READ, PORT_ADDR, 8'h00);
		issue(CMD_READ, PORT_ADDR, 8'h00);
		issue(CMD_WRITE, PORT_ADDR, 8'hFF);
		issue(CMD_READ, PORT_ADDR, 8'hFF);
		issue(CMD_WRITE, PORT_ADDR, 8'h08);
		issue(CMD_WRITE, PORT_ADDR, 8'h18);
		issue(CMD_WRITE, 16'h5555, 8'hAA);
		issue(CMD_WRITE, 16'hAAAA, 8'h55);
		issue(CMD_WRITE, PORT_ADDR, 8'h40);
		issue(CMD_READ, PORT_ADDR, 8'h00);

		// random sessions
		while (port_items < 650) begin
			src_idle_on = ($urandom_range(0, 2) != 0);
			sink_busy_on = ($urandom_range(0, 2) != 0);
			kind = $urandom_range(0, 9);
			case (kind)
				0, 1, 2, 3: begin
					// reply readout, sometimes with the short byte limit
					issue(CMD_WRITE, PORT_ADDR, 8'h00);
					if ($urandom_range(0, 5) == 0) begin
						issue(CMD_WRITE, PORT_ADDR, 8'($urandom) | 8'h20);
						issue(CMD_WRITE, PORT_ADDR, (8'($urandom) & 8'h97) | 8'h01);
						n = $urandom_range(290, 320);
					end else begin
						n = $urandom_range(10, 80);
					end
					for (k = 0; k < n; k++) begin
						if ($urandom_range(0, 15) == 0) begin
							issue(CMD_WRITE, 16'($urandom) | 16'h8000, 8'($urandom));
						end
						issue(CMD_READ, PORT_ADDR, 8'($urandom));
					end
				end
				4, 5, 6: begin
					// serial input transfer, then status polling
					if ($urandom_range(0, 1) == 1) begin
						issue(CMD_WRITE, PORT_ADDR, 8'h00);
					end
					if ($urandom_range(0, 1) == 1) begin
						issue(CMD_WRITE, PORT_ADDR, 8'h20);
					end
					n = $urandom_range(10, 55);
					for (k = 0; k < n; k++) begin
						v = 8'h08 | (8'($urandom) & 8'hB7);
						issue(CMD_WRITE, PORT_ADDR, v);
						if ($urandom_range(0, 3) == 0) begin
							issue(CMD_READ, PORT_ADDR, 8'($urandom));
						end
					end
					n = $urandom_range(1, 50);
					for (k = 0; k < n; k++) begin
						issue(CMD_READ, PORT_ADDR, 8'($urandom));
					end
				end
				7: begin
					// bank latch writes
					n = $urandom_range(1, 8);
					for (k = 0; k < n; k++) begin
						issue(CMD_WRITE, 16'($urandom) | 16'h8000, 8'($urandom));
					end
				end
				default: begin
					// anything at all
					n = $urandom_range(5, 30);
					for (k = 0; k < n; k++) begin
						issue(1'($urandom), ($urandom_range(0, 1) == 1) ? PORT_ADDR : 16'($urandom),
							8'($urandom));
					end
				end
			endcase
			// hold off once until every owed reply is back
			if (!drained && port_items > 300) begin
				s_tvalid <= 1'b0;
				while (shadow.replies.size() != 0) @(negedge clk);
				drained = 1'b1;
			end
		end

		// readout that carries the table index past the short limit
		src_idle_on = 1'b1;
		sink_busy_on = 1'b1;
		issue(CMD_WRITE, PORT_ADDR, 8'h00);
		n = $urandom_range(320, 340);
		for (k = 0; k < n; k++) begin
			if (k == n - 140) begin
				calm = 1'b1;
			end
			issue(CMD_READ, PORT_ADDR, 8'($urandom));
		end
		issue(CMD_WRITE, PORT_ADDR, 8'h20);
		issue(CMD_WRITE, PORT_ADDR, 8'h01);
		tail = 60;
		for (k = 0; k < tail; k++) begin
			issue(CMD_READ, PORT_ADDR, 8'($urandom));
		end

		// drain and let the pipeline settle
		s_tvalid <= 1'b0;
		while (shadow.replies.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		if (shadow.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
`default_nettype wire

### files.f
+incdir+hdl
hdl/cbscp_pkg.sv
hdl/cbscp_port.sv
hdl/cart_bank_and_serial_card_port.sv
tb/sv/tb_cart_bank_and_serial_card_port.sv
